/* sv/frucrc_pkg.sv */
// ----------------------------------------------------------------------------
// frucrc_pkg
// Shared types and constants of the unescaping CRC-8 frame receiver.
// ----------------------------------------------------------------------------
package frucrc_pkg;

  localparam logic [7:0] ESC_A    = 8'h88;
  localparam logic [7:0] ESC_B    = 8'h81;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Request from the front to the back: replay one frame from history.
  typedef struct packed {
    logic [9:0] start;
  } replay_req_t;

  function automatic logic is_escape(input logic [7:0] b);
    return (b == ESC_A) || (b == ESC_B);
  endfunction

  function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] v;
    v = c ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

/* sv/frame_receiver_unescape_crc8_core.sv */
// ----------------------------------------------------------------------------
// frame_receiver_unescape_crc8_core
// Byte-stuffed frame receiver with CRC-8 check and history replay.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// in_     | in  | in_valid/ready   | in_rx_byte
// out_    | out | out_valid/ready  | header fields, payload byte, position, last
// cfg_    | in  | cfg_we           | cfg_wdata (start marker)
//
// One raw byte per cycle while no replay is queued or running. A valid frame
// starts a replay that walks the raw history bytes through the one ring read
// port; input is held off until the last result is taken. Synchronous
// active-low reset; output stalls hold the replay.
// ----------------------------------------------------------------------------
module frame_receiver_unescape_crc8_core #(
  parameter int DATA_BYTES     = 63,
  parameter int MAX_CANDIDATES = 8,
  parameter int HISTORY_DEPTH  = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_payload_length,
  output logic [4:0] out_sequence_res,
  output logic [4:0] out_message_type,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_position,
  output logic       out_last_of_frame
);

  localparam int HIST_W = $clog2(HISTORY_DEPTH);

  logic [7:0]        marker_r;
  logic [HIST_W-1:0] wp_r;
  logic [7:0]        hist [HISTORY_DEPTH];
  logic [7:0]        rd_data_r;
  logic              win_valid, busy, rd_en, q_v_r;
  logic [HIST_W-1:0] win_start, rd_addr;
  frucrc_pkg::replay_req_t q_r;

  wire step = in_valid && in_ready;
  assign in_ready = !busy && !q_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) marker_r <= 8'd126;
    else if (cfg_we) marker_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) wp_r <= '0;
    else if (step) wp_r <= win_valid ? '0 : wp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (step) hist[wp_r] <= in_rx_byte;
    if (rd_en) rd_data_r <= hist[rd_addr];
  end

  // One-entry queue between tracker and replay engine.
  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= 1'b0;
    else if (step && win_valid) begin
      q_v_r   <= 1'b1;
      q_r.start <= 10'(win_start);
    end else if (q_v_r && !busy) q_v_r <= 1'b0;
  end

  frucrc_front #(.DATA_BYTES(DATA_BYTES), .MAX_CANDIDATES(MAX_CANDIDATES),
                 .HIST_W(HIST_W)) u_front (
    .clk, .rst_n, .step, .rx_byte(in_rx_byte), .sof_byte(marker_r),
    .here(wp_r), .win_valid, .win_start
  );

  frucrc_back #(.DATA_BYTES(DATA_BYTES), .HIST_W(HIST_W)) u_back (
    .clk, .rst_n, .req_valid(q_v_r), .req(q_r), .busy, .rd_addr, .rd_en,
    .rd_data(rd_data_r), .out_valid, .out_ready, .out_payload_length,
    .out_sequence_res, .out_message_type, .out_payload_byte,
    .out_byte_position, .out_last_of_frame
  );

  a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready) else $error("input taken during replay");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_frame) |-> (out_byte_position == 6'(DATA_BYTES - 1)))
    else $error("last flag at wrong position");
  a_queue_once: assert property (@(posedge clk) disable iff (!rst_n)
    q_v_r |-> !step) else $error("input taken while replay queued");

endmodule

/* sv/frucrc_front.sv */
// ----------------------------------------------------------------------------
// frucrc_front
// Candidate tracker: per-byte unescape and CRC-8 for every open candidate,
// selection of the oldest valid frame.
// ----------------------------------------------------------------------------
module frucrc_front #(
  parameter int DATA_BYTES     = 63,
  parameter int MAX_CANDIDATES = 8,
  parameter int HIST_W         = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        sof_byte,
  input  logic [HIST_W-1:0] here,
  output logic              win_valid,
  output logic [HIST_W-1:0] win_start
);

  localparam int FRAME_BYTES = DATA_BYTES + 3;

  logic [MAX_CANDIDATES-1:0] act_r, act_nxt, skip_r, skip_nxt;
  logic [HIST_W-1:0]         start_r [MAX_CANDIDATES];
  logic [HIST_W-1:0]         start_nxt [MAX_CANDIDATES];
  logic [6:0]                cnt_r [MAX_CANDIDATES];
  logic [6:0]                cnt_nxt [MAX_CANDIDATES];
  logic [7:0]                crc_r [MAX_CANDIDATES];
  logic [7:0]                crc_nxt [MAX_CANDIDATES];

  always_comb begin
    logic [HIST_W-1:0] best_age, age;
    logic [7:0]        c;
    logic              placed;
    act_nxt   = act_r;
    skip_nxt  = skip_r;
    start_nxt = start_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    win_valid = 1'b0;
    win_start = '0;
    best_age  = '0;
    age       = '0;
    c         = '0;
    placed    = 1'b0;
    for (int i = 0; i < MAX_CANDIDATES; i++) begin
      if (act_r[i]) begin
        if (skip_r[i]) begin
          skip_nxt[i] = 1'b0;
        end else begin
          c           = frucrc_pkg::crc_step(crc_r[i], rx_byte);
          crc_nxt[i]  = c;
          cnt_nxt[i]  = cnt_r[i] + 7'd1;
          skip_nxt[i] = frucrc_pkg::is_escape(rx_byte);
          if (cnt_r[i] + 7'd1 >= 7'(FRAME_BYTES)) begin
            act_nxt[i] = 1'b0;
            age = here - start_r[i];
            if (c == 8'h00 && (!win_valid || age > best_age)) begin
              win_valid = 1'b1;
              best_age  = age;
              win_start = start_r[i];
            end
          end
        end
      end
    end
    if (rx_byte == sof_byte) begin
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
        if (!act_nxt[i] && !placed) begin
          placed       = 1'b1;
          act_nxt[i]   = 1'b1;
          start_nxt[i] = here;
          cnt_nxt[i]   = '0;
          crc_nxt[i]   = '0;
          skip_nxt[i]  = frucrc_pkg::is_escape(rx_byte);
        end
      end
    end
    if (!step) win_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= '0;
      skip_r <= '0;
    end else if (step) begin
      if (win_valid) begin
        act_r  <= '0;
        skip_r <= '0;
      end else begin
        act_r  <= act_nxt;
        skip_r <= skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      start_r <= start_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

/* sv/frucrc_back.sv */
// ----------------------------------------------------------------------------
// frucrc_back
// Replay engine: walks the history ring from the frame start, drops escape
// followers, latches the header and emits one result per data byte.
// ----------------------------------------------------------------------------
module frucrc_back #(
  parameter int DATA_BYTES = 63,
  parameter int HIST_W     = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   req_valid,
  input  frucrc_pkg::replay_req_t req,
  output logic                   busy,
  output logic [HIST_W-1:0]      rd_addr,
  output logic                   rd_en,
  input  logic [7:0]             rd_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [5:0]             out_payload_length,
  output logic [4:0]             out_sequence_res,
  output logic [4:0]             out_message_type,
  output logic [7:0]             out_payload_byte,
  output logic [5:0]             out_byte_position,
  output logic                   out_last_of_frame
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } st_t;

  // got_r value meaning: next returned byte is the marker
  localparam logic [6:0] GOT_MARK = 7'h7F;

  st_t               st_r;
  logic [HIST_W-1:0] pos_r;
  logic              pend_r;   // read issued, result pending in rd_data
  logic              skip_r;
  logic [6:0]        got_r;
  logic [7:0]        h0_r, h1_r;
  logic              ov_r;
  logic [7:0]        ob_r;
  logic [5:0]        op_r;
  logic              ol_r;

  wire out_free = !ov_r || out_ready;
  wire emit     = (st_r == S_WALK) && pend_r && (got_r != GOT_MARK) && !skip_r &&
                  (got_r >= 7'd2) && out_free;
  // Request a read in S_FIRST, or in S_WALK while no read is pending and not all header and data bytes are taken.
  assign rd_addr = pos_r;
  assign rd_en   = (st_r == S_FIRST) ||
                   (st_r == S_WALK && !pend_r && got_r < 7'(DATA_BYTES + 2));
  assign busy    = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (emit) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (req_valid) begin
            st_r  <= S_FIRST;
            pos_r <= req.start[HIST_W-1:0];
            got_r <= '0;
          end
        end
        S_FIRST: begin
          pos_r  <= pos_r + 1'b1;
          pend_r <= 1'b1;
          st_r   <= S_WALK;
          skip_r <= 1'b0;
          got_r  <= GOT_MARK;
        end
        S_WALK: begin
          if (pend_r) begin
            if (got_r == GOT_MARK) begin
              skip_r <= frucrc_pkg::is_escape(rd_data);
              got_r  <= '0;
              pend_r <= 1'b0;
            end else if (skip_r) begin
              skip_r <= 1'b0;
              pend_r <= 1'b0;
            end else if (got_r < 7'd2) begin
              if (got_r == 7'd0) h0_r <= rd_data;
              else h1_r <= rd_data;
              skip_r <= frucrc_pkg::is_escape(rd_data);
              got_r  <= got_r + 7'd1;
              pend_r <= 1'b0;
            end else if (out_free) begin
              ob_r   <= rd_data;
              op_r   <= 6'(got_r - 7'd2);
              ol_r   <= (got_r == 7'(DATA_BYTES + 1));
              skip_r <= frucrc_pkg::is_escape(rd_data);
              got_r  <= got_r + 7'd1;
              pend_r <= 1'b0;
              if (got_r == 7'(DATA_BYTES + 1)) st_r <= S_DONE;
            end
          end else if (rd_en) begin
            pos_r  <= pos_r + 1'b1;
            pend_r <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // A held read result stays in rd_data because the ring read is not re-enabled.
  assign out_valid          = ov_r;
  assign out_payload_length = h0_r[5:0];
  assign out_sequence_res   = {h1_r[2:0], h0_r[7:6]};
  assign out_message_type   = h1_r[7:3];
  assign out_payload_byte   = ob_r;
  assign out_byte_position  = op_r;
  assign out_last_of_frame  = ol_r;

endmodule
